// ===== hdl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared codes, types and helper functions of the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   // Expression characters with a meaning of their own.
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_HAT   = 8'h5E;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   // Codes held on the operator stack.
   typedef logic [2:0] code_type;
   localparam code_type CODE_NONE  = 3'd0;
   localparam code_type CODE_PLUS  = 3'd1;
   localparam code_type CODE_MINUS = 3'd2;
   localparam code_type CODE_STAR  = 3'd3;
   localparam code_type CODE_HAT   = 3'd4;
   localparam code_type CODE_OPEN  = 3'd5;

   // Result kinds.
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_CHAR  = 3'd0;
   localparam kind_type KIND_END   = 3'd1;
   localparam kind_type KIND_OP    = 3'd2;
   localparam kind_type KIND_EXPR  = 3'd3;
   localparam kind_type KIND_ERROR = 3'd4;

   // Results given for one character at most; later ones are dropped.
   localparam int MAX_RESULTS = 36;
   localparam int ECNT_W      = 6;

   // Request from the sequencer to the result stage.
   typedef struct packed {
      logic       emit;
      logic       finish;
      kind_type   kind;
      logic [7:0] ch;
   } emit_type;

   function automatic code_type op_code(input logic [7:0] c);
      code_type code;
      case (c)
         CH_PLUS:  code = CODE_PLUS;
         CH_MINUS: code = CODE_MINUS;
         CH_STAR:  code = CODE_STAR;
         CH_HAT:   code = CODE_HAT;
         default:  code = CODE_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] code_char(input code_type code);
      logic [7:0] c;
      case (code)
         CODE_PLUS:  c = CH_PLUS;
         CODE_MINUS: c = CH_MINUS;
         CODE_STAR:  c = CH_STAR;
         CODE_HAT:   c = CH_HAT;
         CODE_OPEN:  c = CH_OPEN;
         default:    c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] code_prio(input code_type code);
      logic [1:0] p;
      case (code)
         CODE_PLUS:  p = 2'd1;
         CODE_MINUS: p = 2'd1;
         CODE_STAR:  p = 2'd2;
         CODE_HAT:   p = 2'd3;
         default:    p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== hdl/itp_if.sv =====
// ----------------------------------------------------------------------------
// itp_req_if / itp_rsp_if
// Valid/ready channels carrying expression characters and postfix results.
// ----------------------------------------------------------------------------
interface itp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface itp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_kind;
   logic [7:0] out_char;
   logic       out_last;

   modport source (output valid, output out_kind, output out_char, output out_last,
                   input ready);
   modport sink   (input valid, input out_kind, input out_char, input out_last,
                   output ready);
endinterface

// ===== hdl/itp_ram.sv =====
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/itp_cmp.sv =====
// ----------------------------------------------------------------------------
// itp_cmp
// Priority compare unit shared by every pop decision of the sequencer.
// ----------------------------------------------------------------------------
module itp_cmp (
   input  itp_pkg::code_type top_code,
   input  itp_pkg::code_type new_code,
   output logic              top_ge,
   output logic              top_open,
   output logic [7:0]        top_char
);
   import itp_pkg::*;

   assign top_ge   = code_prio(top_code) >= code_prio(new_code);
   assign top_open = top_code == CODE_OPEN;
   assign top_char = code_char(top_code);
endmodule

// ===== hdl/itp_out.sv =====
// ----------------------------------------------------------------------------
// itp_out
// Result stage: holds one result back until the next one is known, so that
// the final beat of a character can carry the last flag, then registers it.
// ----------------------------------------------------------------------------
module itp_out (
   input  logic               clock,
   input  logic               reset,
   input  itp_pkg::emit_type  em,
   output logic               free,
   itp_rsp_if.source          rsp_chan
);
   import itp_pkg::*;

   logic       pend_v_ff, pend_v_in;
   kind_type   pend_kind_ff, pend_kind_in;
   logic [7:0] pend_char_ff, pend_char_in;
   logic       out_v_ff, out_v_in;
   kind_type   out_kind_ff, out_kind_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;

   assign free = !out_v_ff || rsp_chan.ready;

   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_kind_in = pend_kind_ff;
      pend_char_in = pend_char_ff;
      out_v_in     = out_v_ff && !rsp_chan.ready;
      out_kind_in  = out_kind_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      // The sequencer only raises emit or finish while the output is free.
      if (em.emit) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_kind_in = pend_kind_ff;
            out_char_in = pend_char_ff;
            out_last_in = 1'b0;
         end
         pend_v_in    = 1'b1;
         pend_kind_in = em.kind;
         pend_char_in = em.ch;
      end else if (em.finish && pend_v_ff) begin
         out_v_in    = 1'b1;
         out_kind_in = pend_kind_ff;
         out_char_in = pend_char_ff;
         out_last_in = 1'b1;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_char_ff <= pend_char_in;
      out_kind_ff  <= out_kind_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid    = out_v_ff;
   assign rsp_chan.out_kind = out_kind_ff;
   assign rsp_chan.out_char = out_char_ff;
   assign rsp_chan.out_last = out_last_ff;
endmodule

// ===== hdl/infix_to_postfix_converter_core.sv =====
// An operand character goes through IDLE, CLASS, TAIL and FIN; an operator or ')'
// also loops through POP and PWAIT once for each entry that it pops, and the final
// character adds FLUSH and FWAIT for each entry flushed, then ENDX.
// Each pop passes through a wait state because the stack RAM returns its top registered.
// Throughput: one character at a time; ready is low while a character is worked.
// Reset: synchronous; control clears at once, the stack RAM keeps its contents.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: a small sequencer drives one priority compare unit
// and an operator stack in RAM, one push or pop per step.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   itp_req_if.sink   req_chan,
   itp_rsp_if.source rsp_chan
);
   import itp_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CLASS = 9'b000000010,
      ST_POP   = 9'b000000100,
      ST_PWAIT = 9'b000001000,
      ST_TAIL  = 9'b000010000,
      ST_FLUSH = 9'b000100000,
      ST_FWAIT = 9'b001000000,
      ST_ENDX  = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;
   code_type          code_ff, code_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [7:0]        prev_ff, prev_in;
   logic              start_ff, start_in;
   logic              open_ff, open_in;
   logic              err_ff, err_in;
   logic [ECNT_W-1:0] ecnt_ff, ecnt_in;

   logic          go;
   logic          em_req;
   kind_type      em_kind;
   logic [7:0]    em_char;
   logic          em_finish;
   emit_type      em;
   logic          wr_en;
   code_type      wr_data;
   code_type      top_code;
   logic [CW-1:0] cnt_m1;
   logic          top_ge;
   logic          top_open;
   logic [7:0]    top_char;
   logic          unary;
   logic          stack_full;
   logic          is_open_ch;
   logic          is_close_ch;

   assign cnt_m1      = count_ff - CW'(1);
   assign stack_full  = count_ff == CW'(STACK_DEPTH);
   assign is_open_ch  = char_ff == CH_OPEN;
   assign is_close_ch = char_ff == CH_CLOSE;
   assign unary       = (char_ff == CH_MINUS) && (start_ff || (op_code(prev_ff) != CODE_NONE));
   assign wr_data     = is_open_ch ? CODE_OPEN : code_ff;

   itp_ram #(
      .WIDTH ($bits(code_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (cnt_m1[AW-1:0]),
      .rd_data (top_code)
   );

   itp_cmp u_cmp (
      .top_code (top_code),
      .new_code (code_ff),
      .top_ge   (top_ge),
      .top_open (top_open),
      .top_char (top_char)
   );

   always_comb begin
      state_in  = state_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      code_in   = code_ff;
      count_in  = count_ff;
      prev_in   = prev_ff;
      start_in  = start_ff;
      open_in   = open_ff;
      err_in    = err_ff;
      ecnt_in   = ecnt_ff;
      em_req    = 1'b0;
      em_kind   = KIND_CHAR;
      em_char   = 8'h00;
      em_finish = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               char_in  = req_chan.in_char;
               last_in  = req_chan.in_last;
               code_in  = op_code(req_chan.in_char);
               ecnt_in  = '0;
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (go) begin
               prev_in  = char_ff;
               start_in = 1'b0;
               if (err_ff) begin
                  state_in = ST_TAIL;
               end else if (unary || (code_ff == CODE_NONE && !is_open_ch && !is_close_ch)) begin
                  em_req   = 1'b1;
                  em_char  = char_ff;
                  open_in  = 1'b1;
                  state_in = ST_TAIL;
               end else begin
                  if (open_ff) begin
                     em_req  = 1'b1;
                     em_kind = KIND_END;
                     open_in = 1'b0;
                  end
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (go) begin
               if (is_close_ch) begin
                  if (count_ff == '0) begin
                     em_req   = 1'b1;
                     em_kind  = KIND_ERROR;
                     err_in   = 1'b1;
                     open_in  = 1'b0;
                     state_in = ST_TAIL;
                  end else if (!top_open) begin
                     em_req   = 1'b1;
                     em_kind  = KIND_OP;
                     em_char  = top_char;
                     count_in = cnt_m1;
                     state_in = ST_PWAIT;
                  end else begin
                     count_in = cnt_m1;
                     state_in = ST_TAIL;
                  end
               end else if (!is_open_ch && count_ff != '0 && top_ge) begin
                  em_req   = 1'b1;
                  em_kind  = KIND_OP;
                  em_char  = top_char;
                  count_in = cnt_m1;
                  state_in = ST_PWAIT;
               end else begin
                  if (stack_full) begin
                     em_req   = 1'b1;
                     em_kind  = KIND_ERROR;
                     err_in   = 1'b1;
                     count_in = '0;
                     open_in  = 1'b0;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  state_in = ST_TAIL;
               end
            end
         end
         ST_PWAIT: begin
            // Lets the stack RAM present the new top entry before the next pop decision.
            if (go) begin
               state_in = ST_POP;
            end
         end
         ST_TAIL: begin
            if (go) begin
               if (!last_ff) begin
                  state_in = ST_FIN;
               end else if (err_ff) begin
                  state_in = ST_ENDX;
               end else begin
                  if (open_ff) begin
                     em_req  = 1'b1;
                     em_kind = KIND_END;
                     open_in = 1'b0;
                  end
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (go) begin
               if (count_ff != '0) begin
                  em_req   = 1'b1;
                  em_kind  = KIND_OP;
                  em_char  = top_char;
                  count_in = cnt_m1;
                  state_in = ST_FWAIT;
               end else begin
                  state_in = ST_ENDX;
               end
            end
         end
         ST_FWAIT: begin
            if (go) begin
               state_in = ST_FLUSH;
            end
         end
         ST_ENDX: begin
            if (go) begin
               em_req   = 1'b1;
               em_kind  = KIND_EXPR;
               count_in = '0;
               prev_in  = 8'h00;
               start_in = 1'b1;
               open_in  = 1'b0;
               err_in   = 1'b0;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (go) begin
               em_finish = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Results past the per-character limit are dropped; the state still moves.
      if (em_req && ecnt_ff < ECNT_W'(MAX_RESULTS)) begin
         ecnt_in = ecnt_ff + ECNT_W'(1);
      end
   end

   always_comb begin
      em.emit   = em_req && (ecnt_ff < ECNT_W'(MAX_RESULTS));
      em.finish = em_finish;
      em.kind   = em_kind;
      em.ch     = em_char;
   end

   itp_out u_out (
      .clock    (clock),
      .reset    (reset),
      .em       (em),
      .free     (go),
      .rsp_chan (rsp_chan)
   );

   assign req_chan.ready = state_ff == ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         prev_ff  <= 8'h00;
         start_ff <= 1'b1;
         open_ff  <= 1'b0;
         err_ff   <= 1'b0;
         ecnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         prev_ff  <= prev_in;
         start_ff <= start_in;
         open_ff  <= open_in;
         err_ff   <= err_in;
         ecnt_ff  <= ecnt_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      code_ff <= code_in;
   end
endmodule

// ===== hdl/itp_checker.sv =====
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_char,
   input logic       rsp_last
);
   import itp_pkg::*;

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_char)
         && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // The converter works on one character at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a character is in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_CHAR || rsp_kind == KIND_END || rsp_kind == KIND_OP
         || rsp_kind == KIND_EXPR || rsp_kind == KIND_ERROR)
      else $error("result kind out of range");

   // Only operand characters and operator tokens carry a character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END || rsp_kind == KIND_EXPR || rsp_kind == KIND_ERROR)
         |-> rsp_char == 8'h00)
      else $error("nonzero character on a marker result");

   // An expression end always closes the results of its character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EXPR |-> rsp_last)
      else $error("expression end is not the last beat");
endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.out_kind),
   .rsp_char  (rsp_chan.out_char),
   .rsp_last  (rsp_chan.out_last)
);
